>>> rtl/nroot_pkg.sv
// Shared types and constants for the integer n-th root search block.
package nroot_pkg;

   localparam int VALUE_WIDTH_DEF = 32;
   localparam int EXP_W           = 6;
   localparam int TGT_W           = 32;
   localparam int ROOT_W          = 32;
   localparam int REQ_TDATA_W     = 40;
   localparam int RSP_TDATA_W     = 40;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;         // capture a new request, reset the search range
      logic start_probe;  // latch the midpoint, restart the power accumulator
      logic mul_step;     // multiply the accumulator by the midpoint
      logic go_high;      // move the upper bound below the midpoint
      logic go_low;       // move the lower bound above the midpoint
      logic set_hit;      // mark the midpoint as the exact root
      logic publish;      // load the result register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic range_empty;  // low bound above high bound
      logic above;        // power so far exceeds the target
      logic at_power;     // accumulator holds the full power
      logic equal;        // accumulator equals the target
      logic mid_at_high;  // midpoint sits at the top of the range
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_CHECK = 4'b0010,
      S_POWER = 4'b0100,
      S_DONE  = 4'b1000
   } state_type;

endpackage

>>> rtl/nroot_dpath.sv
// Datapath of the n-th root search: search bounds, shared multiplier, result register.
module nroot_dpath
   import nroot_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic             clock,
   input  cmd_type          cmd,
   output status_type       status,
   input  logic [EXP_W-1:0] req_exponent,
   input  logic [TGT_W-1:0] req_target,
   output logic [ROOT_W-1:0] rsp_root,
   output logic             rsp_found
);

   // The target port is 32 bits, so no value in the search ever exceeds that.
   localparam int VW = (VALUE_WIDTH < TGT_W) ? VALUE_WIDTH : TGT_W;

   logic [EXP_W-1:0]  expo_ff, expo_in;
   logic [VW-1:0]     tgt_ff, tgt_in;
   logic [VW-1:0]     low_ff, low_in;
   logic [VW-1:0]     high_ff, high_in;
   logic [VW-1:0]     mid_ff, mid_in;
   logic [2*VW-1:0]   acc_ff, acc_in;
   logic [EXP_W-1:0]  cnt_ff, cnt_in;
   logic              hit_ff, hit_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic              found_ff, found_in;
   logic [2*VW-1:0]   prod;
   logic [2*VW-1:0]   tgt_wide;

   // Accumulator stays at or below the target before a multiply, so its low half suffices.
   assign prod     = (2*VW)'(acc_ff[VW-1:0]) * (2*VW)'(mid_ff);
   assign tgt_wide = (2*VW)'(tgt_ff);

   always_comb begin
      expo_in  = expo_ff;
      tgt_in   = tgt_ff;
      low_in   = low_ff;
      high_in  = high_ff;
      mid_in   = mid_ff;
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      hit_in   = hit_ff;
      root_in  = root_ff;
      found_in = found_ff;
      if (cmd.load) begin
         expo_in = req_exponent;
         tgt_in  = req_target[VW-1:0];
         low_in  = VW'(1);
         high_in = req_target[VW-1:0];
         hit_in  = 1'b0;
      end
      if (cmd.start_probe) begin
         mid_in = low_ff + ((high_ff - low_ff) >> 1);
         acc_in = (2*VW)'(1);
         cnt_in = '0;
      end
      if (cmd.mul_step) begin
         acc_in = prod;
         cnt_in = cnt_ff + EXP_W'(1);
      end
      if (cmd.go_high) begin
         high_in = mid_ff - VW'(1);
      end
      if (cmd.go_low) begin
         low_in = mid_ff + VW'(1);
      end
      if (cmd.set_hit) begin
         hit_in = 1'b1;
      end
      if (cmd.publish) begin
         root_in  = hit_ff ? ROOT_W'(mid_ff) : '0;
         found_in = hit_ff;
      end
   end

   always_ff @(posedge clock) begin
      expo_ff  <= expo_in;
      tgt_ff   <= tgt_in;
      low_ff   <= low_in;
      high_ff  <= high_in;
      mid_ff   <= mid_in;
      acc_ff   <= acc_in;
      cnt_ff   <= cnt_in;
      hit_ff   <= hit_in;
      root_ff  <= root_in;
      found_ff <= found_in;
   end

   assign status.range_empty = low_ff > high_ff;
   assign status.above       = acc_ff > tgt_wide;
   assign status.at_power    = cnt_ff == expo_ff;
   assign status.equal       = acc_ff == tgt_wide;
   assign status.mid_at_high = mid_ff == high_ff;

   assign rsp_root  = root_ff;
   assign rsp_found = found_ff;

endmodule

>>> rtl/nroot_ctrl.sv
// Controller of the n-th root search: sequences probes and power steps, owns the handshakes.
module nroot_ctrl
   import nroot_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output cmd_type    cmd,
   input  status_type status
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (status.range_empty) begin
               state_in = S_DONE;
            end else begin
               cmd.start_probe = 1'b1;
               state_in        = S_POWER;
            end
         end
         S_POWER: begin
            if (status.above) begin
               cmd.go_high = 1'b1;
               state_in    = S_CHECK;
            end else if (status.at_power) begin
               if (status.equal) begin
                  cmd.set_hit = 1'b1;
                  state_in    = S_DONE;
               end else if (status.mid_at_high) begin
                  // top of the range still below the target: no root
                  state_in = S_DONE;
               end else begin
                  cmd.go_low = 1'b1;
                  state_in   = S_CHECK;
               end
            end else begin
               cmd.mul_step = 1'b1;
            end
         end
         S_DONE: begin
            // hold until the result register is free
            if (out_free) begin
               cmd.publish  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/integer_nth_root_search_top.sv
// Each binary-search probe passes S_CHECK, which latches the midpoint, then S_POWER, which
// multiplies; S_DONE then publishes the result, also when S_CHECK finds the range empty.
// A probe stops at the exponent or once the power passes the target: at most 32 multiplies,
// up to 63 only when the midpoint is 1. One item is in the search at a time, and the next
// request is taken while the result still waits.
// Reset (synchronous) clears the controller and the output valid; nothing else is cleared.
module integer_nth_root_search_top
   import nroot_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // exponent[5:0], target[37:6], zero[39:38]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata    // root[31:0], found[32], zero[39:33]
);

   cmd_type           cmd;
   status_type        status;
   logic [ROOT_W-1:0] root;
   logic              found;

   nroot_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   nroot_dpath #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dpath (
      .clock        (clock),
      .cmd          (cmd),
      .status       (status),
      .req_exponent (req_tdata[EXP_W-1:0]),
      .req_target   (req_tdata[EXP_W+TGT_W-1:EXP_W]),
      .rsp_root     (root),
      .rsp_found    (found)
   );

   assign rsp_tdata = {{(RSP_TDATA_W-ROOT_W-1){1'b0}}, found, root};

endmodule
